FILE: design/particle_pixel_size_clamp_top_macros.svh
// Assertion macros shared by the checker of the particle pixel size clamp.
// No dependencies.
`ifndef PARTICLE_PIXEL_SIZE_CLAMP_TOP_MACROS_SVH
`define PARTICLE_PIXEL_SIZE_CLAMP_TOP_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define PPSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Antecedent implies consequent in the next cycle.
`define PPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: design/ppsc_pkg.sv
// Package of the particle pixel size clamp: register codes, configuration and sideband types.
// No dependencies.
package ppsc_pkg;
   localparam logic [31:0] DIST_FLOOR = 32'd64;
   localparam logic [15:0] ALPHA_ONE  = 16'd32768;
   localparam logic [31:0] PIX_ONE    = 32'd65536;
   localparam int          CSR_IW     = 4;

   typedef enum logic [CSR_IW-1:0] {
      CSR_VIEW_X   = 4'd0,
      CSR_VIEW_Y   = 4'd1,
      CSR_VIEW_Z   = 4'd2,
      CSR_OFFSET   = 4'd3,
      CSR_MIN_PIX  = 4'd4,
      CSR_MAX_PIX  = 4'd5,
      CSR_SCALE    = 4'd6,
      CSR_AFFECT   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [17:0] view_dir_x;
      logic signed [17:0] view_dir_y;
      logic signed [17:0] view_dir_z;
      logic signed [31:0] plane_offset;
      logic [31:0]        min_pixel;
      logic [31:0]        max_pixel;
      logic [31:0]        draw_scale;
      logic               affect_opacity;
   } cfg_type;

   typedef struct packed {
      logic [15:0] alpha;
      logic        sat;
   } main_side_type;

   typedef struct packed {
      logic [15:0] alpha;
      logic [63:0] p;
      logic [31:0] pix1;
      logic        use_div;
      logic [15:0] r15_fix;
   } cov_side_type;
endpackage

FILE: design/ppsc_front.sv
// Front end: view-plane dot product, distance clamp, scale product and divider set-up.
// Depends on ppsc_pkg.
module ppsc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ppsc_pkg::cfg_type   cfg,
   input  logic                in_valid,
   input  logic signed [31:0]  pos_x,
   input  logic signed [31:0]  pos_y,
   input  logic signed [31:0]  pos_z,
   input  logic [31:0]         size_in,
   input  logic [15:0]         alpha_in,
   output logic                out_valid,
   output logic [63:0]         out_rem,
   output logic [63:0]         out_p,
   output ppsc_pkg::main_side_type out_side
);
   import ppsc_pkg::*;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [49:0] px_ff, py_ff, pz_ff;
   logic [31:0]        size1_ff, size2_ff, size3_ff, size4_ff;
   logic [15:0]        a1_ff, a2_ff, a3_ff, a4_ff;
   logic signed [51:0] sum_ff;
   logic signed [36:0] dist_in;
   logic [31:0]        d_in, d_ff;
   logic [63:0]        p_ff, rem_in, rem_ff, p5_ff;
   main_side_type      side_ff;

   always_comb begin
      dist_in = 37'($signed(sum_ff[51:16])) + 37'(cfg.plane_offset);
      if (dist_in[36] || (dist_in[35:0] < 36'(DIST_FLOOR))) begin
         d_in = DIST_FLOOR;
      end else if (dist_in[35:32] != 4'd0) begin
         d_in = 32'hFFFF_FFFF;
      end else begin
         d_in = dist_in[31:0];
      end
      rem_in = {16'd0, size4_ff, 16'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff    <= cfg.view_dir_x * pos_x;
         py_ff    <= cfg.view_dir_y * pos_y;
         pz_ff    <= cfg.view_dir_z * pos_z;
         size1_ff <= size_in;
         a1_ff    <= (alpha_in > ALPHA_ONE) ? ALPHA_ONE : alpha_in;
         sum_ff   <= 52'(px_ff) + 52'(py_ff) + 52'(pz_ff);
         size2_ff <= size1_ff;
         a2_ff    <= a1_ff;
         d_ff     <= d_in;
         size3_ff <= size2_ff;
         a3_ff    <= a2_ff;
         p_ff     <= 64'(d_ff) * 64'(cfg.draw_scale);
         size4_ff <= size3_ff;
         a4_ff    <= a3_ff;
         rem_ff        <= rem_in;
         p5_ff         <= p_ff;
         side_ff.alpha <= a4_ff;
         side_ff.sat   <= (p_ff == 64'd0) || (p_ff <= rem_in);
      end
   end

   assign out_valid = v5_ff;
   assign out_rem   = rem_ff;
   assign out_p     = p5_ff;
   assign out_side  = side_ff;
endmodule

FILE: design/ppsc_divpipe.sv
// Restoring divider pipeline, one quotient bit per register stage, with a sideband.
// No package dependencies.
module ppsc_divpipe #(
   parameter int W  = 64,
   parameter int QW = 32,
   parameter int SW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [W-1:0]  in_rem,
   input  logic [W-1:0]  in_dvs,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [W-1:0]  out_dvs,
   output logic [SW-1:0] out_side
);
   logic [QW-1:0] v_ff;
   logic [W-1:0]  rem_ff  [QW];
   logic [W-1:0]  dvs_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [W-1:0]  rem_in  [QW];
   logic [QW-1:0] quo_in  [QW];

   always_comb begin
      logic [W:0] sh;
      for (int i = 0; i < QW; i++) begin
         if (i == 0) begin
            sh = {in_rem, 1'b0};
            if (sh >= {1'b0, in_dvs}) begin
               rem_in[i] = W'(sh - {1'b0, in_dvs});
               quo_in[i] = QW'(1);
            end else begin
               rem_in[i] = sh[W-1:0];
               quo_in[i] = '0;
            end
         end else begin
            sh = {rem_ff[i-1], 1'b0};
            if (sh >= {1'b0, dvs_ff[i-1]}) begin
               rem_in[i] = W'(sh - {1'b0, dvs_ff[i-1]});
               quo_in[i] = {quo_ff[i-1][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = sh[W-1:0];
               quo_in[i] = {quo_ff[i-1][QW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[QW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < QW; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            if (i == 0) begin
               dvs_ff[i]  <= in_dvs;
               side_ff[i] <= in_side;
            end else begin
               dvs_ff[i]  <= dvs_ff[i-1];
               side_ff[i] <= side_ff[i-1];
            end
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_dvs   = dvs_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule

FILE: design/ppsc_clamp.sv
// Screen size saturation, pixel clamp and coverage set-up for the second divider.
// Depends on ppsc_pkg.
module ppsc_clamp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  ppsc_pkg::cfg_type       cfg,
   input  logic                    in_valid,
   input  logic [31:0]             in_quo,
   input  logic [63:0]             in_p,
   input  ppsc_pkg::main_side_type in_side,
   output logic                    out_valid,
   output logic [31:0]             out_pix0,
   output ppsc_pkg::cov_side_type  out_side
);
   import ppsc_pkg::*;

   logic         va_ff, vb_ff;
   logic [31:0]  pix0_in, pix1_in, hi_in, pix0_ff, pix1_ff, pix0b_ff;
   logic [63:0]  p_ff;
   logic [15:0]  alpha_ff;
   cov_side_type side_in, side_ff;

   always_comb begin
      pix0_in = in_side.sat ? 32'hFFFF_FFFF : in_quo;
      hi_in   = (cfg.max_pixel != 32'd0) ? cfg.max_pixel : 32'hFFFF_FFFF;
      pix1_in = (pix0_in < hi_in) ? pix0_in : hi_in;
      if (pix1_in < cfg.min_pixel) begin
         pix1_in = cfg.min_pixel;
      end
      side_in.alpha   = alpha_ff;
      side_in.p       = p_ff;
      side_in.pix1    = pix1_ff;
      side_in.use_div = 1'b0;
      side_in.r15_fix = ALPHA_ONE;
      if (cfg.min_pixel == 32'd0) begin
         if (pix0_ff < PIX_ONE) begin
            side_in.r15_fix = {1'b0, pix0_ff[15:1]};
         end
      end else if (pix0_ff < cfg.min_pixel) begin
         side_in.use_div = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix0_ff  <= pix0_in;
         pix1_ff  <= pix1_in;
         p_ff     <= in_p;
         alpha_ff <= in_side.alpha;
         pix0b_ff <= pix0_ff;
         side_ff  <= side_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_pix0  = pix0b_ff;
   assign out_side  = side_ff;
endmodule

FILE: design/ppsc_rescale.sv
// Back end: world size rescale with saturation and alpha coverage scaling.
// Depends on ppsc_pkg.
module ppsc_rescale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ppsc_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   input  logic [14:0]            in_quo,
   input  ppsc_pkg::cov_side_type in_side,
   output logic                   out_valid,
   output logic [31:0]            size_out,
   output logic [15:0]            alpha_out
);
   import ppsc_pkg::*;

   logic        vc_ff, vd_ff;
   logic [63:0] a_ff, b_ff;
   logic [15:0] r15_ff, alpha_ff, alpha_in, alpha_res_ff;
   logic [32:0] mid_in, hi_in;
   logic [31:0] size_in, size_res_ff;
   logic [31:0] aprod;

   always_comb begin
      mid_in  = 33'(a_ff[63:32]) + 33'(b_ff[31:0]);
      hi_in   = 33'(b_ff[63:32]) + 33'(mid_in[32]);
      size_in = (hi_in[32:16] != 17'd0) ? 32'hFFFF_FFFF : {hi_in[15:0], mid_in[31:16]};
      aprod   = 32'(alpha_ff) * 32'(r15_ff);
      alpha_in = cfg.affect_opacity ? aprod[30:15] : alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (advance) begin
         vc_ff <= in_valid;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff         <= 64'(in_side.pix1) * 64'(in_side.p[31:0]);
         b_ff         <= 64'(in_side.pix1) * 64'(in_side.p[63:32]);
         r15_ff       <= in_side.use_div ? {1'b0, in_quo} : in_side.r15_fix;
         alpha_ff     <= in_side.alpha;
         size_res_ff  <= size_in;
         alpha_res_ff <= alpha_in;
      end
   end

   assign out_valid = vd_ff;
   assign size_out  = size_res_ff;
   assign alpha_out = alpha_res_ff;
endmodule

FILE: design/particle_pixel_size_clamp_top.sv
// Top level of the particle pixel size clamp: registers, stall control and pipeline.
// Depends on ppsc_pkg, ppsc_front, ppsc_divpipe, ppsc_clamp and ppsc_rescale.
//
// One particle item enters per cycle whenever the pipeline advances. The pipeline is
// the front stages, the two restoring dividers, 32 stages for the screen size and
// 15 for the coverage ratio, the clamp stages and the back multiplier stages. The whole
// pipeline advances whenever the result register is empty or being taken, so
// req_ready is high exactly when it advances. Configuration writes are always accepted.
module particle_pixel_size_clamp_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic signed [31:0]            req_pos_z,
   input  logic [31:0]                   req_size_in,
   input  logic [15:0]                   req_alpha_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_size_out,
   output logic [15:0]                   rsp_alpha_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ppsc_pkg::CSR_IW-1:0]   csr_index,
   input  logic [31:0]                   csr_data
);
   import ppsc_pkg::*;

   cfg_type       cfg_ff;
   logic          advance;
   logic          f_valid, m_valid, c_valid;
   logic [63:0]   f_rem, f_p, m_p, c_dvs_unused_sink;
   main_side_type f_side, m_side;
   logic [31:0]   m_quo, c_pix0, k_dvs;
   cov_side_type  c_side, k_side;
   logic [14:0]   k_quo;
   logic          k_valid;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;
   assign c_dvs_unused_sink = m_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_dir_x     <= 18'sd0;
         cfg_ff.view_dir_y     <= 18'sd0;
         cfg_ff.view_dir_z     <= 18'sd65536;
         cfg_ff.plane_offset   <= 32'sd0;
         cfg_ff.min_pixel      <= 32'd262144;
         cfg_ff.max_pixel      <= 32'd0;
         cfg_ff.draw_scale     <= 32'd0;
         cfg_ff.affect_opacity <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VIEW_X:  cfg_ff.view_dir_x     <= csr_data[17:0];
            CSR_VIEW_Y:  cfg_ff.view_dir_y     <= csr_data[17:0];
            CSR_VIEW_Z:  cfg_ff.view_dir_z     <= csr_data[17:0];
            CSR_OFFSET:  cfg_ff.plane_offset   <= csr_data;
            CSR_MIN_PIX: cfg_ff.min_pixel      <= csr_data;
            CSR_MAX_PIX: cfg_ff.max_pixel      <= csr_data;
            CSR_SCALE:   cfg_ff.draw_scale     <= csr_data;
            CSR_AFFECT:  cfg_ff.affect_opacity <= csr_data[0];
            default: ;
         endcase
      end
   end

   ppsc_front u_front (
      .clock, .reset, .advance, .cfg(cfg_ff),
      .in_valid(req_valid && advance),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .size_in(req_size_in), .alpha_in(req_alpha_in),
      .out_valid(f_valid), .out_rem(f_rem), .out_p(f_p), .out_side(f_side)
   );

   ppsc_divpipe #(.W(64), .QW(32), .SW($bits(main_side_type))) u_div_size (
      .clock, .reset, .advance,
      .in_valid(f_valid), .in_rem(f_rem), .in_dvs(f_p), .in_side(f_side),
      .out_valid(m_valid), .out_quo(m_quo), .out_dvs(m_p), .out_side(m_side)
   );

   ppsc_clamp u_clamp (
      .clock, .reset, .advance, .cfg(cfg_ff),
      .in_valid(m_valid), .in_quo(m_quo), .in_p(c_dvs_unused_sink), .in_side(m_side),
      .out_valid(c_valid), .out_pix0(c_pix0), .out_side(c_side)
   );

   ppsc_divpipe #(.W(32), .QW(15), .SW($bits(cov_side_type))) u_div_cov (
      .clock, .reset, .advance,
      .in_valid(c_valid), .in_rem(c_pix0), .in_dvs(cfg_ff.min_pixel), .in_side(c_side),
      .out_valid(k_valid), .out_quo(k_quo), .out_dvs(k_dvs), .out_side(k_side)
   );

   ppsc_rescale u_rescale (
      .clock, .reset, .advance, .cfg(cfg_ff),
      .in_valid(k_valid && (k_dvs == k_dvs)), .in_quo(k_quo), .in_side(k_side),
      .out_valid(rsp_valid), .size_out(rsp_size_out), .alpha_out(rsp_alpha_out)
   );
endmodule

FILE: design/ppsc_checker.sv
// Port-level checker for the particle pixel size clamp, bound to the top level.
// Depends on particle_pixel_size_clamp_top_macros.svh.
`include "particle_pixel_size_clamp_top_macros.svh"
module ppsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_alpha_out
);
   `PPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")
   `PPSC_ASSERT_NOW(a_ready_empty, clock, reset, !rsp_valid, req_ready, "not ready with empty output")
   `PPSC_ASSERT_NOW(a_stall_back, clock, reset, rsp_valid && !rsp_ready, !req_ready, "item taken during stall")
   `PPSC_ASSERT_NOW(a_alpha_range, clock, reset, rsp_valid, rsp_alpha_out <= 16'd32768, "alpha above one")
endmodule

bind particle_pixel_size_clamp_top ppsc_checker u_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the particle pixel size clamp: random particles and settings,
// with idle and stall bursts on both sides, checked against an in-bench predictor.
// Depends on ppsc_pkg and particle_pixel_size_clamp_top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ppsc_pkg::*;

   localparam logic [CSR_IW-1:0] CSR_SPARE_LO = CSR_AFFECT + CSR_IW'(1);
   localparam logic [CSR_IW-1:0] CSR_SPARE_HI = '1;
   localparam logic [31:0]       U32_ALL      = 32'hFFFF_FFFF;

   typedef struct {
      logic [31:0] size;
      logic [15:0] alpha;
   } sized_particle_type;

   class clamp_scoreboard;
      cfg_type            cfg;
      sized_particle_type pending[$];
      int                 mismatches;

      function automatic sized_particle_type predict(logic signed [31:0] px,
         logic signed [31:0] py, logic signed [31:0] pz, logic [31:0] sz, logic [15:0] a);
         longint             dot;
         longint             plane_dist;
         logic [63:0]        d;
         logic [63:0]        p;
         logic [95:0]        prod;
         logic [31:0]        pix0;
         logic [31:0]        pix1;
         logic [31:0]        lim;
         logic [47:0]        al;
         logic [47:0]        r15;
         sized_particle_type r;
         dot = longint'(cfg.view_dir_x) * longint'(px) + longint'(cfg.view_dir_y) * longint'(py)
             + longint'(cfg.view_dir_z) * longint'(pz);
         plane_dist = (dot >>> 16) + longint'(cfg.plane_offset);
         if (plane_dist < longint'(DIST_FLOOR)) d = {32'd0, DIST_FLOOR};
         else if (plane_dist > 64'sd4294967295) d = {32'd0, U32_ALL};
         else d = plane_dist;
         p = d * {32'd0, cfg.draw_scale};
         if (p == 0 || p <= {16'd0, sz, 16'd0}) pix0 = U32_ALL;
         else pix0 = 32'({16'd0, sz, 48'd0} / {32'd0, p});
         lim = (cfg.max_pixel != 0) ? cfg.max_pixel : U32_ALL;
         pix1 = (pix0 < lim) ? pix0 : lim;
         if (pix1 < cfg.min_pixel) pix1 = cfg.min_pixel;
         al = (a > ALPHA_ONE) ? 48'(ALPHA_ONE) : 48'(a);
         if (cfg.affect_opacity) begin
            if (cfg.min_pixel == 0) r15 = (pix0 >= PIX_ONE) ? 48'(ALPHA_ONE) : 48'(pix0 >> 1);
            else if (pix0 >= cfg.min_pixel) r15 = 48'(ALPHA_ONE);
            else r15 = {1'b0, pix0, 15'd0} / {16'd0, cfg.min_pixel};
            al = (al * r15) >> 15;
         end
         prod = {32'd0, pix1} * {32'd0, p};
         r.size = (prod[95:80] != 0) ? U32_ALL : prod[79:48];
         r.alpha = al[15:0];
         return r;
      endfunction

      function void note(logic signed [31:0] px, logic signed [31:0] py,
         logic signed [31:0] pz, logic [31:0] sz, logic [15:0] a);
         pending.push_back(predict(px, py, pz, sz, a));
      endfunction

      function void check(logic [31:0] size, logic [15:0] alpha);
         sized_particle_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: size %h alpha %h", size, alpha);
            return;
         end
         e = pending.pop_front();
         if (e.size !== size || e.alpha !== alpha) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: size exp %h got %h, alpha exp %h got %h",
                        e.size, size, e.alpha, alpha);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [31:0]   req_pos_x;
   logic signed [31:0]   req_pos_y;
   logic signed [31:0]   req_pos_z;
   logic [31:0]          req_size_in;
   logic [15:0]          req_alpha_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [31:0]          rsp_size_out;
   logic [15:0]          rsp_alpha_out;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IW-1:0]    csr_index;
   logic [31:0]          csr_data;
   logic                 quiet;
   clamp_scoreboard      sb;

   particle_pixel_size_clamp_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note(req_pos_x, req_pos_y, req_pos_z, req_size_in, req_alpha_in);
         if (rsp_valid && rsp_ready) sb.check(rsp_size_out, rsp_alpha_out);
      end
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_VIEW_X:  sb.cfg.view_dir_x     = data[17:0];
         CSR_VIEW_Y:  sb.cfg.view_dir_y     = data[17:0];
         CSR_VIEW_Z:  sb.cfg.view_dir_z     = data[17:0];
         CSR_OFFSET:  sb.cfg.plane_offset   = data;
         CSR_MIN_PIX: sb.cfg.min_pixel      = data;
         CSR_MAX_PIX: sb.cfg.max_pixel      = data;
         CSR_SCALE:   sb.cfg.draw_scale     = data;
         CSR_AFFECT:  sb.cfg.affect_opacity = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(cfg_type c);
      write_reg(CSR_VIEW_X, 32'(c.view_dir_x));
      write_reg(CSR_VIEW_Y, 32'(c.view_dir_y));
      write_reg(CSR_VIEW_Z, 32'(c.view_dir_z));
      write_reg(CSR_OFFSET, c.plane_offset);
      write_reg(CSR_MIN_PIX, c.min_pixel);
      write_reg(CSR_MAX_PIX, c.max_pixel);
      write_reg(CSR_SCALE, c.draw_scale);
      write_reg(CSR_AFFECT, {$urandom} & ~32'd1 | 32'(c.affect_opacity));
      write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
   endtask

   task automatic send_particle(logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] pz, logic [31:0] sz, logic [15:0] a);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_pos_x    <= px;
      req_pos_y    <= py;
      req_pos_z    <= pz;
      req_size_in  <= sz;
      req_alpha_in <= a;
      do @(posedge clock); while (!req_ready);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_random_particle;
      if ($urandom_range(0, 9) < 7)
         send_particle($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                       $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                       $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                       $urandom_range(0, 32'h000F_FFFF), 16'($urandom_range(0, 32768)));
      else
         send_particle($urandom, $urandom, $urandom, $urandom, 16'($urandom));
   endtask

   function automatic cfg_type pick_settings(int ph);
      cfg_type c;
      c.view_dir_x     = 18'($signed($urandom_range(0, 131072)) - 65536);
      c.view_dir_y     = 18'($signed($urandom_range(0, 131072)) - 65536);
      c.view_dir_z     = 18'($signed($urandom_range(0, 131072)) - 65536);
      c.plane_offset   = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      c.min_pixel      = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 32'h0010_0000);
      c.max_pixel      = $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(1, 32'h0040_0000);
      c.draw_scale     = $urandom_range(32'h0001_0000, 32'h0400_0000);
      c.affect_opacity = $urandom_range(0, 3) != 0;
      case (ph)
         1: begin
            c.view_dir_x = 18'sd65536;
            c.view_dir_y = -18'sd65536;
            c.view_dir_z = -18'sd65536;
            c.plane_offset = 32'sh7FFF_FFFF;
            c.min_pixel = U32_ALL;
            c.max_pixel = U32_ALL;
            c.draw_scale = U32_ALL;
         end
         2: begin
            c.view_dir_x = -18'sd65536;
            c.plane_offset = 32'sh8000_0000;
            c.min_pixel = 32'd0;
            c.max_pixel = 32'd1;
            c.draw_scale = 32'd1;
            c.affect_opacity = 1'b1;
         end
         3: c.draw_scale = 32'd0;
         4: begin
            c.min_pixel = 32'h0020_0000;
            c.max_pixel = 32'h0001_0000;
         end
         5: c.plane_offset = $urandom;
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      cfg_type c;
      sb = new();
      sb.cfg = '{view_dir_x: 18'sd0, view_dir_y: 18'sd0, view_dir_z: 18'sd65536,
                 plane_offset: 32'sd0, min_pixel: 32'd262144, max_pixel: 32'd0,
                 draw_scale: 32'd0, affect_opacity: 1'b1};
      quiet        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_pos_x    = '0;
      req_pos_y    = '0;
      req_pos_z    = '0;
      req_size_in  = '0;
      req_alpha_in = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings first: the screen size saturates with a zero draw scale.
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0001_0000, ALPHA_ONE);
      drain();
      c = '{view_dir_x: 18'sd0, view_dir_y: 18'sd0, view_dir_z: 18'sd65536,
            plane_offset: 32'sd0, min_pixel: 32'h0004_0000, max_pixel: 32'h0100_0000,
            draw_scale: 32'h0040_0000, affect_opacity: 1'b1};
      load_settings(c);
      send_particle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, U32_ALL, 16'hFFFF);
      send_particle(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'd0, 16'd0);
      send_particle(32'sd0, 32'sd0, -32'sh0001_0000, 32'h0001_0000, ALPHA_ONE);
      send_particle(32'sd0, 32'sd0, 32'sh0000_0040, 32'h0001_0000, 16'h4000);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0000_0100, 16'h7FFF);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0010_0000, ALPHA_ONE);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, U32_ALL, 16'h8001);
      send_particle(32'sd0, 32'sd0, 32'sh0100_0000, 32'h0000_4000, 16'h2000);
      send_particle(32'sd0, 32'sd0, 32'sh0000_1000, 32'h0800_0000, 16'h1234);
      drain();
      c.affect_opacity = 1'b0;
      c.min_pixel = 32'h0800_0000;
      c.max_pixel = 32'h0002_0000;
      load_settings(c);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0001_0000, 16'hFFFF);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0100_0000, 16'h5555);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0000_0001, 16'hAAAA);
      drain();
      c.affect_opacity = 1'b1;
      c.min_pixel = 32'd0;
      c.max_pixel = 32'd0;
      load_settings(c);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0000_0800, ALPHA_ONE);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0004_0000, ALPHA_ONE);
      send_particle(32'sd0, 32'sd0, 32'sh0010_0000, 32'h0000_0010, 16'h6000);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         load_settings(pick_settings(ph));
         if (ph == 9) quiet = 1'b1;
         repeat (50) send_random_particle();
         drain();
      end

      if (sb.mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

FILE: particle_pixel_size_clamp_top.f
+incdir+design
design/ppsc_pkg.sv
design/ppsc_front.sv
design/ppsc_divpipe.sv
design/ppsc_clamp.sv
design/ppsc_rescale.sv
design/particle_pixel_size_clamp_top.sv
design/ppsc_checker.sv
dv/tb_top.sv
